FILE: rtl/rc4_stream_cipher_defines.svh
// Assertion macros used by the rc4_checker module.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define RC4_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc4 check failed: next-cycle property");

// Consequent must hold in the cycle after reset is seen.
`define RC4_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("rc4 check failed: state after reset");

`endif

FILE: rtl/rc4_pkg.sv
package rc4_pkg;

  localparam int KEY_BYTES_MAX = 256;
  localparam int KEY_CNT_W     = $clog2(KEY_BYTES_MAX + 1);
  localparam int SBOX_DEPTH    = 256;
  localparam int BYTE_W        = 8;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;
    logic              last_mark;
  } rc4_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              last_out;
  } rc4_result_t;

  typedef struct packed {
    logic              rd_en;
    logic [BYTE_W-1:0] rd_addr;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              clear;
  } rc4_sbox_ctl_t;

  typedef struct packed {
    logic              wr_en;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] rd_addr;
  } rc4_key_ctl_t;

endpackage

FILE: rtl/rc4_sbox_ram.sv
module rc4_sbox_ram
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rc4_sbox_ctl_t     ctl,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0]     mem [SBOX_DEPTH];
  logic [SBOX_DEPTH-1:0] valid;
  logic [BYTE_W-1:0]     mem_q;
  logic [BYTE_W-1:0]     addr_q;
  logic                  vld_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      mem_q  <= mem[ctl.rd_addr];
      addr_q <= ctl.rd_addr;
      vld_q  <= valid[ctl.rd_addr];
    end
  end

  // An entry not written since the last clear or reset reads as the identity value.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[ctl.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = vld_q ? mem_q : addr_q;

endmodule

FILE: rtl/rc4_key_ram.sv
module rc4_key_ram
  import rc4_pkg::*;
(
  input  logic              clk,
  input  rc4_key_ctl_t      ctl,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [SBOX_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data <= mem[ctl.rd_addr];
  end

endmodule

FILE: rtl/rc4_ctrl.sv
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  rc4_item_t         item,
  output logic              busy,
  input  logic [BYTE_W-1:0] sbox_rd_data,
  input  logic [BYTE_W-1:0] key_rd_data,
  output rc4_sbox_ctl_t     sbox_ctl,
  output rc4_key_ctl_t      key_ctl,
  input  logic              res_free,
  output logic              res_valid,
  output rc4_result_t       res
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_KS_RD  = 8'b0000_0010,
    ST_KS_SW  = 8'b0000_0100,
    ST_KS_WN  = 8'b0000_1000,
    ST_KS_WJ  = 8'b0001_0000,
    ST_PG_J   = 8'b0010_0000,
    ST_PG_T   = 8'b0100_0000,
    ST_PG_OUT = 8'b1000_0000
  } rc4_state_t;

  rc4_state_t           state, state_next;
  logic [BYTE_W-1:0]    i, i_next;
  logic [BYTE_W-1:0]    j, j_next;
  logic [BYTE_W-1:0]    k, k_next;
  logic [BYTE_W-1:0]    held, held_next;
  logic [BYTE_W-1:0]    sj, sj_next;
  logic [BYTE_W-1:0]    t, t_next;
  logic [BYTE_W-1:0]    byte_q, byte_next;
  logic                 last_q, last_next;
  logic [KEY_CNT_W-1:0] key_count, key_count_next;
  logic [KEY_CNT_W-1:0] key_len, key_len_next;

  logic                 key_room;
  logic [KEY_CNT_W-1:0] key_count_inc;
  logic [KEY_CNT_W-1:0] k_inc;
  logic [BYTE_W-1:0]    ks_byte;

  assign busy          = (state != ST_IDLE);
  assign key_room      = (key_count < KEY_CNT_W'(KEY_BYTES_MAX));
  assign key_count_inc = key_room ? key_count + KEY_CNT_W'(1) : key_count;
  assign k_inc         = {1'b0, k} + KEY_CNT_W'(1);

  // Only S[i] and S[j] moved since S[t] was read.
  always_comb begin
    if (t == j) begin
      ks_byte = held;
    end else if (t == i) begin
      ks_byte = sj;
    end else begin
      ks_byte = sbox_rd_data;
    end
  end

  assign res.data_out = byte_q ^ ks_byte;
  assign res.last_out = last_q;

  always_comb begin
    state_next     = state;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    held_next      = held;
    sj_next        = sj;
    t_next         = t;
    byte_next      = byte_q;
    last_next      = last_q;
    key_count_next = key_count;
    key_len_next   = key_len;
    sbox_ctl       = '0;
    key_ctl.wr_en   = 1'b0;
    key_ctl.wr_addr = key_count[BYTE_W-1:0];
    key_ctl.wr_data = item.data_byte;
    key_ctl.rd_addr = k;
    res_valid      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item.opcode == OP_DATA) begin
            i_next           = i + 8'd1;
            sbox_ctl.rd_en   = 1'b1;
            sbox_ctl.rd_addr = i + 8'd1;
            byte_next        = item.data_byte;
            last_next        = item.last_mark;
            state_next       = ST_PG_J;
          end else begin
            // Drop key bytes past the maximum length.
            key_ctl.wr_en = key_room;
            if (item.last_mark) begin
              key_len_next   = key_count_inc;
              key_count_next = '0;
              i_next         = '0;
              j_next         = '0;
              k_next         = '0;
              sbox_ctl.clear = 1'b1;
              state_next     = ST_KS_RD;
            end else begin
              key_count_next = key_count_inc;
            end
          end
        end
      end
      ST_KS_RD: begin
        sbox_ctl.rd_en   = 1'b1;
        sbox_ctl.rd_addr = i;
        state_next       = ST_KS_SW;
      end
      ST_KS_SW: begin
        j_next           = j + sbox_rd_data + key_rd_data;
        held_next        = sbox_rd_data;
        sbox_ctl.rd_en   = 1'b1;
        sbox_ctl.rd_addr = j + sbox_rd_data + key_rd_data;
        state_next       = ST_KS_WN;
      end
      ST_KS_WN: begin
        sbox_ctl.wr_en   = 1'b1;
        sbox_ctl.wr_addr = i;
        sbox_ctl.wr_data = sbox_rd_data;
        state_next       = ST_KS_WJ;
      end
      ST_KS_WJ: begin
        sbox_ctl.wr_en   = 1'b1;
        sbox_ctl.wr_addr = j;
        sbox_ctl.wr_data = held;
        k_next           = (k_inc >= key_len) ? '0 : k_inc[BYTE_W-1:0];
        i_next           = i + 8'd1;
        if (i == 8'hFF) begin
          j_next     = '0;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_KS_RD;
        end
      end
      ST_PG_J: begin
        j_next           = j + sbox_rd_data;
        held_next        = sbox_rd_data;
        sbox_ctl.rd_en   = 1'b1;
        sbox_ctl.rd_addr = j + sbox_rd_data;
        state_next       = ST_PG_T;
      end
      ST_PG_T: begin
        sbox_ctl.wr_en   = 1'b1;
        sbox_ctl.wr_addr = i;
        sbox_ctl.wr_data = sbox_rd_data;
        sj_next          = sbox_rd_data;
        t_next           = held + sbox_rd_data;
        sbox_ctl.rd_en   = 1'b1;
        sbox_ctl.rd_addr = held + sbox_rd_data;
        state_next       = ST_PG_OUT;
      end
      ST_PG_OUT: begin
        // Repeating this write while held is harmless.
        sbox_ctl.wr_en   = 1'b1;
        sbox_ctl.wr_addr = j;
        sbox_ctl.wr_data = held;
        if (res_free) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      key_count <= '0;
      key_len   <= '0;
    end else begin
      state     <= state_next;
      i         <= i_next;
      j         <= j_next;
      k         <= k_next;
      key_count <= key_count_next;
      key_len   <= key_len_next;
    end
  end

  always_ff @(posedge clk) begin
    held   <= held_next;
    sj     <= sj_next;
    t      <= t_next;
    byte_q <= byte_next;
    last_q <= last_next;
  end

endmodule

FILE: rtl/rc4_stream_cipher.sv
// RC4 byte cipher.
// Input channel (item_valid / item_stall / item): opcode OP_KEY loads one key
// byte; the key byte with last_mark set ends the key and starts the key
// schedule. Opcode OP_DATA returns data_byte XOR the next keystream byte.
// Output channel (result_valid / result_stall / result): one transaction per
// data item, last_out copies last_mark; key items give none.
// Steps: a key byte that does not end the key is accepted without raising
// item_stall. The last key byte starts the schedule: 256 swaps, each made of
// two dependent state-memory reads, then the two swap writes. A data item
// runs three dependent state-memory reads plus the second swap write; its
// result is registered as it leaves ST_PG_OUT, once the output register is free.
// item_stall is high while an item or the schedule is in progress.
// A stalled result stays in the output register; the next item is still
// accepted, and a data item waits in its last step until the register frees up.
// Reset: the permutation reads as identity, indices and the key count clear;
// no clearing pass is needed, and the key store contents are undefined.
module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  rc4_item_t   item,
  output logic        result_valid,
  input  logic        result_stall,
  output rc4_result_t result
);

  rc4_sbox_ctl_t     sbox_ctl;
  rc4_key_ctl_t      key_ctl;
  logic [BYTE_W-1:0] sbox_rd_data;
  logic [BYTE_W-1:0] key_rd_data;
  logic              res_free;
  logic              res_valid;
  rc4_result_t       res;

  assign res_free = !result_valid || !result_stall;

  rc4_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .busy         (item_stall),
    .sbox_rd_data (sbox_rd_data),
    .key_rd_data  (key_rd_data),
    .sbox_ctl     (sbox_ctl),
    .key_ctl      (key_ctl),
    .res_free     (res_free),
    .res_valid    (res_valid),
    .res          (res)
  );

  rc4_sbox_ram u_sbox (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sbox_ctl),
    .rd_data (sbox_rd_data)
  );

  rc4_key_ram u_key (
    .clk     (clk),
    .ctl     (key_ctl),
    .rd_data (key_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      result <= res;
    end
  end

endmodule

FILE: rtl/rc4_checker.sv
`include "rc4_stream_cipher_defines.svh"

module rc4_checker
  import rc4_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input rc4_item_t   item,
  input logic        result_valid,
  input logic        result_stall,
  input rc4_result_t result
);

  logic data_take;
  logic key_end_take;

  assign data_take    = item_valid && !item_stall && (item.opcode == OP_DATA);
  assign key_end_take = item_valid && !item_stall && (item.opcode == OP_KEY) &&
                        item.last_mark;

  `RC4_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
    result_valid && $stable(result))
  `RC4_ASSERT_NEXT(a_data_busy, clk, rst, data_take, item_stall)
  `RC4_ASSERT_NEXT(a_schedule_busy, clk, rst, key_end_take, item_stall ##1 item_stall)
  `RC4_ASSERT_AFTER_RESET(a_reset_idle, clk, rst, !item_stall && !result_valid)

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

FILE: verif/rc4_stream_cipher_checker.sv
`timescale 1ns / 1ps

module rc4_stream_cipher_checker
  import rc4_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_stall,
  input  rc4_item_t    item,
  input  logic         result_valid,
  input  logic         result_stall,
  input  rc4_result_t  result,
  output int unsigned  mismatch_count,
  output int unsigned  outstanding
);

  logic [BYTE_W-1:0]    sbox    [SBOX_DEPTH];
  logic [BYTE_W-1:0]    key_mem [KEY_BYTES_MAX];
  logic [KEY_CNT_W-1:0] key_len;
  logic [BYTE_W-1:0]    idx_i;
  logic [BYTE_W-1:0]    idx_j;
  rc4_result_t          cipher_q[$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  function automatic void set_identity();
    for (int n = 0; n < SBOX_DEPTH; n++) sbox[n] = BYTE_W'(n);
  endfunction

  function automatic void run_key_schedule(input int unsigned len);
    logic [BYTE_W-1:0] held;
    logic [BYTE_W-1:0] j;
    int unsigned       k;
    j = '0;
    k = 0;
    set_identity();
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      held = sbox[n];
      j = j + held + key_mem[k];
      k++;
      if (k >= len) k = 0;
      sbox[n] = sbox[j];
      sbox[j] = held;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  function automatic void load_key_byte(input rc4_item_t it);
    // drop bytes past the key store, but still honor the last mark
    if (key_len < KEY_BYTES_MAX) begin
      key_mem[key_len[BYTE_W-1:0]] = it.data_byte;
      key_len++;
    end
    if (it.last_mark) begin
      run_key_schedule(32'(key_len));
      key_len = '0;
    end
  endfunction

  function automatic rc4_result_t cipher_byte(input rc4_item_t it);
    logic [BYTE_W-1:0] si;
    logic [BYTE_W-1:0] sj;
    logic [BYTE_W-1:0] t;
    rc4_result_t       r;
    idx_i = idx_i + BYTE_W'(1);
    si = sbox[idx_i];
    idx_j = idx_j + si;
    sj = sbox[idx_j];
    sbox[idx_i] = sj;
    sbox[idx_j] = si;
    t = si + sj;
    r.data_out = it.data_byte ^ sbox[t];
    r.last_out = it.last_mark;
    return r;
  endfunction

  always @(posedge clk) begin : track
    rc4_result_t want;
    if (rst) begin
      set_identity();
      key_len = '0;
      idx_i = '0;
      idx_j = '0;
      cipher_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected result transaction: data_out %02h last_out %b",
                 result.data_out, result.last_out);
          mismatch_count++;
        end else begin
          want = cipher_q.pop_front();
          if (result.data_out !== want.data_out) begin
            $error("data_out mismatch: expected %02h, got %02h",
                   want.data_out, result.data_out);
            mismatch_count++;
          end
          if (result.last_out !== want.last_out) begin
            $error("last_out mismatch: expected %b, got %b",
                   want.last_out, result.last_out);
            mismatch_count++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (item.opcode == OP_DATA) cipher_q.push_back(cipher_byte(item));
        else load_key_byte(item);
      end
    end
    outstanding <= cipher_q.size();
  end

endmodule

FILE: verif/rc4_stream_cipher_tb.sv
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 1100;
  localparam int ITEM_TARGET = 400;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  rc4_item_t   item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  rc4_result_t result;
  int unsigned mismatch_count;
  int unsigned outstanding;

  int unsigned tx_gap_max   = 17;
  int unsigned rx_gap_max   = 17;
  bit          hold_request = 1'b0;
  bit          hold_done    = 1'b0;

  int unsigned items_sent    = 0;
  int unsigned key_fill      = 0;
  int unsigned keys_done     = 0;
  int unsigned longest_key   = 0;
  int unsigned dropped_bytes = 0;
  int unsigned data_sent     = 0;

  rc4_stream_cipher uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  rc4_stream_cipher_checker watch (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic offer_item(input logic op, input logic [BYTE_W-1:0] value, input logic last);
    int unsigned gap;
    rc4_item_t   next_item;
    gap = $urandom_range(tx_gap_max, 0);
    next_item.opcode    = op;
    next_item.data_byte = value;
    next_item.last_mark = last;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= next_item;
    do @(posedge clk); while (item_stall);
    if (op == OP_DATA) begin
      data_sent++;
      items_sent++;
    end else begin
      if (key_fill < KEY_BYTES_MAX) begin
        key_fill++;
        items_sent++;
      end else begin
        dropped_bytes++;
      end
      if (last) begin
        keys_done++;
        if (key_fill > longest_key) longest_key = key_fill;
        key_fill = 0;
      end
    end
  endtask

  // result side: random stalls per transaction, plus one long hold
  initial begin
    int unsigned wait_n;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request && !hold_done) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        wait_n = $urandom_range(rx_gap_max, 0);
        if (wait_n > 0) begin
          result_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    int unsigned s;
    int unsigned key_bytes;
    int unsigned n_data;
    bit          end_key;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // keystream from the reset permutation, before any key
    offer_item(OP_DATA, 8'h00, 1'b0);
    offer_item(OP_DATA, 8'hff, 1'b1);
    offer_item(OP_DATA, 8'h5a, 1'b0);
    // single-byte key
    offer_item(OP_KEY, 8'hff, 1'b1);
    offer_item(OP_DATA, 8'h00, 1'b0);
    offer_item(OP_DATA, 8'hff, 1'b1);
    // data in the middle of a key keeps the previous schedule
    offer_item(OP_KEY, 8'h00, 1'b0);
    offer_item(OP_KEY, 8'h00, 1'b0);
    offer_item(OP_DATA, 8'h81, 1'b0);
    offer_item(OP_KEY, 8'hff, 1'b1);
    offer_item(OP_DATA, 8'hff, 1'b0);
    offer_item(OP_DATA, 8'h00, 1'b1);
    offer_item(OP_KEY, 8'h01, 1'b0);
    offer_item(OP_KEY, 8'h23, 1'b0);
    offer_item(OP_KEY, 8'h45, 1'b0);
    offer_item(OP_KEY, 8'h67, 1'b0);
    offer_item(OP_KEY, 8'h89, 1'b0);
    offer_item(OP_KEY, 8'hab, 1'b0);
    offer_item(OP_KEY, 8'hcd, 1'b0);
    offer_item(OP_KEY, 8'hef, 1'b1);
    offer_item(OP_DATA, 8'h00, 1'b0);
    offer_item(OP_DATA, 8'h00, 1'b0);
    offer_item(OP_DATA, 8'h00, 1'b1);

    s = 0;
    while (items_sent < ITEM_TARGET || s <= 4) begin
      tx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 17;
      rx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 17;
      // force a full-length key and an overrunning key early on
      if (s == 2) key_bytes = KEY_BYTES_MAX;
      else if (s == 4) key_bytes = KEY_BYTES_MAX + 4;
      else if ($urandom_range(29, 0) == 0) key_bytes = $urandom_range(300, 200);
      else key_bytes = $urandom_range(16, 1);
      end_key = ($urandom_range(9, 0) != 0) || s == 2 || s == 4;
      for (int n = 0; n < key_bytes; n++) begin
        if ($urandom_range(11, 0) == 0)
          offer_item(OP_DATA, BYTE_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
        offer_item(OP_KEY, BYTE_W'($urandom_range(255, 0)), end_key && n == key_bytes - 1);
      end
      if (s == 1) begin
        // back-to-back data against the long output hold
        hold_request = 1'b1;
        tx_gap_max = 0;
        n_data = 16;
      end else begin
        n_data = $urandom_range(20, 1);
      end
      for (int n = 0; n < n_data; n++)
        offer_item(OP_DATA, BYTE_W'($urandom_range(255, 0)),
                   n == n_data - 1 || $urandom_range(15, 0) == 0);
      s++;
    end
    item_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d key schedules (longest key %0d bytes, %0d overrun bytes dropped)",
             keys_done, longest_key, dropped_bytes);
    $display("and %0d data bytes under random gaps and a %0d-cycle output hold",
             data_sent, HOLD_CYCLES);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
